// ===== hw/rtl/stne_pkg.sv =====
// stne_pkg: shared constants and types for the stream token number extractor
// no dependencies; used by the top level and its port checker

package stne_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 5;
  localparam int CNT_W      = 4;
  localparam int DIGITS_W   = 32;
  localparam int NIBBLE_W   = 4;
  localparam int TOKEN_SLOTS = 16;
  localparam int DIGIT_SLOTS = DIGITS_W / NIBBLE_W;

  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LAST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT  = 2'd3;

  localparam logic [LEN_W-1:0] TOKEN_LENGTH_RESET = 5'd1;
  localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET  = 4'd4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [DIGITS_W-1:0] digits_t;

endpackage

// ===== hw/rtl/stream_token_number_extractor.sv =====
// stream_token_number_extractor: token search and decimal field capture on a byte stream
// depends on stne_pkg; one input register, one result register

// Takes one response byte per cycle while the result register is not stalled, and finds
// the first occurrence of a configured token (1 to 16 bytes) with a parallel compare
// across a shift window, then captures up to digit_count decimal digits (capped at
// MAX_DIGITS and 8) and stops at the first non-digit. One result per response: when
// the value completes, or at end_of_response. The input register takes the item, and
// the state update then loads the result register. The window compare plus the state
// update sit in the single stage between those registers. A full result register
// whose item is not taken holds the stage, and the input register behind it.
// The user must write configuration only while no item is in flight;
// the block itself does not enforce this.

module stream_token_number_extractor #(
  parameter int MAX_TOKEN_BYTES = 16,
  parameter int MAX_DIGITS      = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stne_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stne_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [stne_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              byte_valid,
  input  logic                              end_of_response,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stne_pkg::DIGITS_W-1:0]     value_digits,
  output logic [stne_pkg::CNT_W-1:0]        digits_received,
  output logic                              found
);

  localparam int FILL_W    = $clog2(MAX_TOKEN_BYTES + 1);
  localparam int DIGIT_CAP = (MAX_DIGITS > stne_pkg::DIGIT_SLOTS) ?
                             stne_pkg::DIGIT_SLOTS : MAX_DIGITS;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_TOKEN_BYTES);
  localparam logic [stne_pkg::LEN_W-1:0] LEN_MAX = stne_pkg::LEN_W'(MAX_TOKEN_BYTES);
  localparam logic [stne_pkg::CNT_W-1:0] CNT_CAP = stne_pkg::CNT_W'(DIGIT_CAP);

  // configuration registers
  logic [stne_pkg::CFG_DATA_W-1:0] token_first_bytes;
  logic [stne_pkg::CFG_DATA_W-1:0] token_last_bytes;
  logic [stne_pkg::LEN_W-1:0]      token_length;
  logic [stne_pkg::CNT_W-1:0]      digit_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_first_bytes <= '0;
      token_last_bytes  <= '0;
      token_length      <= stne_pkg::TOKEN_LENGTH_RESET;
      digit_count       <= stne_pkg::DIGIT_COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stne_pkg::REG_TOKEN_FIRST:  token_first_bytes <= cfg_data;
        stne_pkg::REG_TOKEN_LAST:   token_last_bytes  <= cfg_data;
        stne_pkg::REG_TOKEN_LENGTH: token_length <= cfg_data[stne_pkg::LEN_W-1:0];
        stne_pkg::REG_DIGIT_COUNT:  digit_count  <= cfg_data[stne_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic            q_valid;
  stne_pkg::byte_t q_byte;
  logic            q_byte_valid;
  logic            q_end;
  logic            advance;

  assign advance  = q_valid && (!out_valid || out_ready);
  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte       <= data_byte;
      q_byte_valid <= byte_valid;
      q_end        <= end_of_response;
    end
  end

  // match state
  stne_pkg::byte_t            win [MAX_TOKEN_BYTES];
  logic [FILL_W-1:0]          fill;
  logic                       token_seen;
  stne_pkg::digits_t          captured;
  logic [stne_pkg::CNT_W-1:0] count;
  logic                       value_done;

  stne_pkg::byte_t            win_next [MAX_TOKEN_BYTES];
  logic [FILL_W-1:0]          fill_next;
  logic                       token_seen_next;
  stne_pkg::digits_t          captured_next;
  logic [stne_pkg::CNT_W-1:0] count_next;
  logic                       value_done_next;

  // effective token length and digit limit
  logic [stne_pkg::LEN_W-1:0] eff_len;
  logic [stne_pkg::CNT_W-1:0] eff_digits;

  always_comb begin
    priority if (token_length == '0) eff_len = stne_pkg::LEN_W'(1);
    else if (token_length > LEN_MAX) eff_len = LEN_MAX;
    else eff_len = token_length;
    priority if (digit_count == '0) eff_digits = stne_pkg::CNT_W'(1);
    else if (digit_count > CNT_CAP) eff_digits = CNT_CAP;
    else eff_digits = digit_count;
  end

  stne_pkg::byte_t tok [stne_pkg::TOKEN_SLOTS];

  always_comb begin
    for (int k = 0; k < stne_pkg::TOKEN_SLOTS; k++) begin
      if (k < 8) tok[k] = token_first_bytes[8*k +: 8];
      else       tok[k] = token_last_bytes[8*(k-8) +: 8];
    end
  end

  // window after shifting in the current byte, and its compare
  stne_pkg::byte_t            shifted [MAX_TOKEN_BYTES];
  logic [FILL_W-1:0]          fill_shifted;
  logic [MAX_TOKEN_BYTES-1:0] lane_ok;
  logic [stne_pkg::LEN_W-1:0] tok_idx [MAX_TOKEN_BYTES];
  logic                       window_match;

  always_comb begin
    shifted[0] = q_byte;
    for (int i = 1; i < MAX_TOKEN_BYTES; i++) shifted[i] = win[i-1];
    fill_shifted = (fill == FILL_MAX) ? fill : fill + FILL_W'(1);
    for (int j = 0; j < MAX_TOKEN_BYTES; j++) begin
      // newest byte lines up with the last token byte
      tok_idx[j] = eff_len - stne_pkg::LEN_W'(1) - stne_pkg::LEN_W'(j);
      lane_ok[j] = (stne_pkg::LEN_W'(j) >= eff_len) || (shifted[j] == tok[tok_idx[j][3:0]]);
    end
    window_match = (stne_pkg::LEN_W'(fill_shifted) >= eff_len) && (&lane_ok);
  end

  logic                       is_digit;
  logic [stne_pkg::CNT_W-1:0] count_inc;
  logic                       emit;

  assign is_digit  = (q_byte >= stne_pkg::CHAR_ZERO) && (q_byte <= stne_pkg::CHAR_NINE);
  assign count_inc = count + stne_pkg::CNT_W'(1);

  always_comb begin
    win_next        = win;
    fill_next       = fill;
    token_seen_next = token_seen;
    captured_next   = captured;
    count_next      = count;
    value_done_next = value_done;
    emit            = 1'b0;
    if (q_byte_valid && !value_done) begin
      priority if (!token_seen) begin
        win_next        = shifted;
        fill_next       = fill_shifted;
        token_seen_next = window_match;
      end else if (is_digit) begin
        captured_next = {captured[stne_pkg::DIGITS_W-stne_pkg::NIBBLE_W-1:0],
                         q_byte[stne_pkg::NIBBLE_W-1:0]};
        count_next    = count_inc;
        if (count_inc >= eff_digits) begin
          value_done_next = 1'b1;
          emit            = 1'b1;
        end
      end else begin
        value_done_next = 1'b1;
        emit            = 1'b1;
      end
    end
    // end of response reports once if the value never completed
    if (q_end && !value_done_next) emit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TOKEN_BYTES; i++) win[i] <= '0;
      fill       <= '0;
      token_seen <= 1'b0;
      captured   <= '0;
      count      <= '0;
      value_done <= 1'b0;
    end else if (advance) begin
      if (q_end) begin
        for (int i = 0; i < MAX_TOKEN_BYTES; i++) win[i] <= '0;
        fill       <= '0;
        token_seen <= 1'b0;
        captured   <= '0;
        count      <= '0;
        value_done <= 1'b0;
      end else begin
        win        <= win_next;
        fill       <= fill_next;
        token_seen <= token_seen_next;
        captured   <= captured_next;
        count      <= count_next;
        value_done <= value_done_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      value_digits    <= token_seen_next ? captured_next : '0;
      digits_received <= token_seen_next ? count_next : '0;
      found           <= token_seen_next;
    end
  end

endmodule

// ===== hw/rtl/stne_checker.sv =====
// stne_checker: port-level checks for the stream token number extractor
// depends on stne_pkg; bound to the top level below

module stne_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [stne_pkg::DIGITS_W-1:0]     value_digits,
  input logic [stne_pkg::CNT_W-1:0]        digits_received,
  input logic                              found
);

  // a stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_digits) &&
                                $stable(digits_received) && $stable(found))
    else $error("result item changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // token absent means an empty value
  a_not_found_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> value_digits == '0 && digits_received == '0)
    else $error("digits reported without token");

  // leading nibbles beyond the captured digits stay zero
  a_leading_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digits_received <= stne_pkg::CNT_W'(stne_pkg::DIGIT_SLOTS) &&
      ({32'b0, value_digits} >> ({2'b0, digits_received} * 6'd4)) == 64'b0)
    else $error("digits outside the captured count");

endmodule

bind stream_token_number_extractor stne_checker u_stne_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .value_digits(value_digits),
  .digits_received(digits_received), .found(found)
);
